// ===== rtl/qvr_pkg.sv =====
package qvr_pkg;

  // Components per quaternion and their slots
  localparam int QUAT_N = 4;
  localparam int IX = 0;
  localparam int IY = 1;
  localparam int IZ = 2;
  localparam int IW = 3;

endpackage

// ===== rtl/qvr_qmul.sv =====
// Pipelined Hamilton product r = p * q (or p * conj(q)), each component >>> FRAC.
// Stage 1 registers the sixteen partial products, stage 2 the shifted sums.
module qvr_qmul import qvr_pkg::*; #(
  parameter int AW   = 16,
  parameter int BW   = 16,
  parameter int FRAC = 14,
  parameter bit CONJ = 1'b0,
  parameter int OW   = AW + BW + 2 - FRAC
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [AW-1:0] p [QUAT_N],
  input  logic signed [BW-1:0] q [QUAT_N],
  output logic                 out_valid,
  output logic signed [OW-1:0] r [QUAT_N]
);

  localparam int PW = AW + BW;
  localparam int SW = PW + 2;

  logic                 prod_valid;
  logic signed [PW-1:0] prod [QUAT_N][QUAT_N];
  logic signed [SW-1:0] e    [QUAT_N][QUAT_N];
  logic signed [SW-1:0] sum  [QUAT_N];
  logic signed [SW-1:0] shr  [QUAT_N];

  // Stage 1: all partial products p[i] * q[j]
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUAT_N; i++) begin
      for (int j = 0; j < QUAT_N; j++) begin
        prod[i][j] <= p[i] * q[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
  end

  // Sign-extend products to the sum width
  always_comb begin
    for (int i = 0; i < QUAT_N; i++) begin
      for (int j = 0; j < QUAT_N; j++) begin
        e[i][j] = SW'(prod[i][j]);
      end
    end
  end

  // Component sums; conjugate flips every term that uses q's vector part
  generate
    if (CONJ) begin : g_conj
      always_comb begin
        sum[IX] = e[IX][IW] - e[IW][IX] - e[IY][IZ] + e[IZ][IY];
        sum[IY] = e[IY][IW] - e[IW][IY] - e[IZ][IX] + e[IX][IZ];
        sum[IZ] = e[IZ][IW] - e[IW][IZ] - e[IX][IY] + e[IY][IX];
        sum[IW] = e[IW][IW] + e[IX][IX] + e[IY][IY] + e[IZ][IZ];
      end
    end else begin : g_plain
      always_comb begin
        sum[IX] = e[IW][IX] + e[IX][IW] + e[IY][IZ] - e[IZ][IY];
        sum[IY] = e[IW][IY] + e[IY][IW] + e[IZ][IX] - e[IX][IZ];
        sum[IZ] = e[IW][IZ] + e[IZ][IW] + e[IX][IY] - e[IY][IX];
        sum[IW] = e[IW][IW] - e[IX][IX] - e[IY][IY] - e[IZ][IZ];
      end
    end
  endgenerate

  // Stage 2: arithmetic shift (truncating) and register
  always_comb begin
    for (int i = 0; i < QUAT_N; i++) begin
      shr[i] = sum[i] >>> FRAC;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUAT_N; i++) begin
      r[i] <= shr[i][OW-1:0];
    end
  end

endmodule

// ===== rtl/qvr_sat.sv =====
// Clamp four wide components to DW bits; registered, flags any clamp.
module qvr_sat import qvr_pkg::*; #(
  parameter int IW_ = 40,
  parameter int DW  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [IW_-1:0] v [QUAT_N],
  output logic                  out_valid,
  output logic signed [DW-1:0]  o [QUAT_N],
  output logic                  sat
);

  logic signed [DW-1:0] o_next [QUAT_N];
  logic                 sat_next;
  logic [QUAT_N-1:0]    clip;

  // A value fits when all bits from DW-1 upward match the sign
  always_comb begin
    for (int i = 0; i < QUAT_N; i++) begin
      clip[i] = (v[i][IW_-1:DW-1] != {(IW_-DW+1){v[i][IW_-1]}});
      if (!clip[i]) begin
        o_next[i] = v[i][DW-1:0];
      end else if (v[i][IW_-1]) begin
        o_next[i] = {1'b1, {(DW-1){1'b0}}};
      end else begin
        o_next[i] = {1'b0, {(DW-1){1'b1}}};
      end
    end
    sat_next = |clip;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUAT_N; i++) begin
      o[i] <= o_next[i];
    end
    sat <= sat_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

endmodule

// ===== rtl/quaternion_vector_rotate_unit.sv =====
// Channel   Handshake           Payload
// request   start / busy        rot_x rot_y rot_z rot_w vec_x vec_y vec_z vec_w
// result    done (strobe)       out_x out_y out_z out_w saturated
//
// Five-stage pipeline: q*v products, q*v sums, t*conj(q) products,
// t*conj(q) sums, clamp. A request is taken every cycle; each result
// shows on done as it leaves the clamp stage, in the order taken.
// busy is always low: results cannot be held off, so nothing stalls.
// rst clears only the valid bits travelling with the data.
module quaternion_vector_rotate_unit import qvr_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] rot_x,
  input  logic signed [DATA_WIDTH-1:0] rot_y,
  input  logic signed [DATA_WIDTH-1:0] rot_z,
  input  logic signed [DATA_WIDTH-1:0] rot_w,
  input  logic signed [DATA_WIDTH-1:0] vec_x,
  input  logic signed [DATA_WIDTH-1:0] vec_y,
  input  logic signed [DATA_WIDTH-1:0] vec_z,
  input  logic signed [DATA_WIDTH-1:0] vec_w,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] out_x,
  output logic signed [DATA_WIDTH-1:0] out_y,
  output logic signed [DATA_WIDTH-1:0] out_z,
  output logic signed [DATA_WIDTH-1:0] out_w,
  output logic                         saturated
);

  localparam int TW = 2 * DATA_WIDTH + 2 - FRAC_BITS;
  localparam int RW = TW + DATA_WIDTH + 2 - FRAC_BITS;

  logic signed [DATA_WIDTH-1:0] rot   [QUAT_N];
  logic signed [DATA_WIDTH-1:0] vec   [QUAT_N];
  logic signed [DATA_WIDTH-1:0] rot_d1 [QUAT_N];
  logic signed [DATA_WIDTH-1:0] rot_d2 [QUAT_N];
  logic signed [TW-1:0]         t     [QUAT_N];
  logic signed [RW-1:0]         rr    [QUAT_N];
  logic signed [DATA_WIDTH-1:0] res   [QUAT_N];
  logic                         t_valid;
  logic                         r_valid;

  assign busy = 1'b0;

  assign rot[IX] = rot_x;
  assign rot[IY] = rot_y;
  assign rot[IZ] = rot_z;
  assign rot[IW] = rot_w;
  assign vec[IX] = vec_x;
  assign vec[IY] = vec_y;
  assign vec[IZ] = vec_z;
  assign vec[IW] = vec_w;

  // t = q * v
  qvr_qmul #(
    .AW(DATA_WIDTH), .BW(DATA_WIDTH), .FRAC(FRAC_BITS), .CONJ(1'b0), .OW(TW)
  ) u_qv (
    .clk(clk), .rst(rst), .in_valid(start), .p(rot), .q(vec),
    .out_valid(t_valid), .r(t)
  );

  // Keep q aligned with t for the second product
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUAT_N; i++) begin
      rot_d1[i] <= rot[i];
      rot_d2[i] <= rot_d1[i];
    end
  end

  // r = t * conj(q)
  qvr_qmul #(
    .AW(TW), .BW(DATA_WIDTH), .FRAC(FRAC_BITS), .CONJ(1'b1), .OW(RW)
  ) u_tq (
    .clk(clk), .rst(rst), .in_valid(t_valid), .p(t), .q(rot_d2),
    .out_valid(r_valid), .r(rr)
  );

  // Clamp and present the result
  qvr_sat #(
    .IW_(RW), .DW(DATA_WIDTH)
  ) u_sat (
    .clk(clk), .rst(rst), .in_valid(r_valid), .v(rr),
    .out_valid(done), .o(res), .sat(saturated)
  );

  assign out_x = res[IX];
  assign out_y = res[IY];
  assign out_z = res[IZ];
  assign out_w = res[IW];

endmodule

// ===== verif/quaternion_vector_rotate_unit_tb.sv =====
`timescale 1ns / 1ps

module quaternion_vector_rotate_unit_tb;

  localparam int DW = 16;
  localparam int FRAC = 14;
  localparam int RAND_REQS = 1050;
  localparam longint SAT_MAX = (longint'(1) << (DW - 1)) - 1;
  localparam longint SAT_MIN = -SAT_MAX - 1;

  typedef struct {
    logic signed [DW-1:0] rx, ry, rz, rw;
    logic signed [DW-1:0] vx, vy, vz, vw;
  } rot_req_t;

  typedef struct {
    logic signed [DW-1:0] x, y, z, w;
    logic                 sat;
  } rot_res_t;

  typedef struct {
    longint x, y, z, w;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [DW-1:0] rot_x = '0;
  logic signed [DW-1:0] rot_y = '0;
  logic signed [DW-1:0] rot_z = '0;
  logic signed [DW-1:0] rot_w = '0;
  logic signed [DW-1:0] vec_x = '0;
  logic signed [DW-1:0] vec_y = '0;
  logic signed [DW-1:0] vec_z = '0;
  logic signed [DW-1:0] vec_w = '0;
  logic done;
  logic signed [DW-1:0] out_x, out_y, out_z, out_w;
  logic saturated;

  rot_req_t pending_reqs[$];
  rot_res_t rotated_q[$];
  int accepted_n = 0;
  int issued_n = 0;
  int total_reqs = 0;
  int mismatch_n = 0;
  int gap_left = 0;
  int burst_left = 0;

  quaternion_vector_rotate_unit #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FRAC)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .rot_x    (rot_x),
    .rot_y    (rot_y),
    .rot_z    (rot_z),
    .rot_w    (rot_w),
    .vec_x    (vec_x),
    .vec_y    (vec_y),
    .vec_z    (vec_z),
    .vec_w    (vec_w),
    .done     (done),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .out_w    (out_w),
    .saturated(saturated)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hamilton product p*q at full width, each component floored by FRAC bits
  function automatic quat_t hamilton(quat_t p, quat_t q);
    quat_t r;
    r.x = (p.w * q.x + q.w * p.x + p.y * q.z - p.z * q.y) >>> FRAC;
    r.y = (p.w * q.y + q.w * p.y + p.z * q.x - p.x * q.z) >>> FRAC;
    r.z = (p.w * q.z + q.w * p.z + p.x * q.y - p.y * q.x) >>> FRAC;
    r.w = (p.w * q.w - (p.x * q.x + p.y * q.y + p.z * q.z)) >>> FRAC;
    return r;
  endfunction

  function automatic logic signed [DW-1:0] clamp_out(longint v, output logic clipped);
    clipped = 1'b0;
    if (v > SAT_MAX) begin
      clipped = 1'b1;
      return DW'(SAT_MAX);
    end
    if (v < SAT_MIN) begin
      clipped = 1'b1;
      return DW'(SAT_MIN);
    end
    return DW'(v);
  endfunction

  // r = (q * v) * conj(q); only the final components saturate
  function automatic rot_res_t rotate_predict(rot_req_t req);
    quat_t q, v, qc, t, r;
    rot_res_t res;
    logic c0, c1, c2, c3;
    q = '{x: req.rx, y: req.ry, z: req.rz, w: req.rw};
    v = '{x: req.vx, y: req.vy, z: req.vz, w: req.vw};
    qc = '{x: -q.x, y: -q.y, z: -q.z, w: q.w};
    t = hamilton(q, v);
    r = hamilton(t, qc);
    res.x = clamp_out(r.x, c0);
    res.y = clamp_out(r.y, c1);
    res.z = clamp_out(r.z, c2);
    res.w = clamp_out(r.w, c3);
    res.sat = c0 | c1 | c2 | c3;
    return res;
  endfunction

  task automatic add_req(int rx, int ry, int rz, int rw, int vx, int vy, int vz, int vw);
    rot_req_t r;
    r = '{rx: DW'(rx), ry: DW'(ry), rz: DW'(rz), rw: DW'(rw),
          vx: DW'(vx), vy: DW'(vy), vz: DW'(vz), vw: DW'(vw)};
    pending_reqs = {pending_reqs, r};
  endtask

  // 0: any value, 1: within +/-1.0, else a corner value
  function automatic int pick_field(int mode);
    if (mode == 0) return int'($signed(16'($urandom)));
    if (mode == 1) return int'($urandom_range(0, 32768)) - 16384;
    case ($urandom_range(0, 6))
      0: return -32768;
      1: return -16384;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 16384;
      default: return 32767;
    endcase
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_n++;
    end
  endtask

  // Driver: present the next request once the current one is taken
  always @(negedge clk) begin : drv
    rot_req_t req;
    int roll;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || accepted_n == issued_n) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending_reqs.size() > 0) begin
        req = pending_reqs.pop_front();
        rot_x <= req.rx;
        rot_y <= req.ry;
        rot_z <= req.rz;
        rot_w <= req.rw;
        vec_x <= req.vx;
        vec_y <= req.vy;
        vec_z <= req.vz;
        vec_w <= req.vw;
        start <= 1'b1;
        issued_n++;
        // gap before the next request; bursts run back to back
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 3) burst_left = $urandom_range(40, 150);
          if (roll < 55) gap_left = 0;
          else if (roll < 88) gap_left = $urandom_range(1, 3);
          else if (roll < 97) gap_left = $urandom_range(4, 12);
          else gap_left = $urandom_range(20, 60);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predict each accepted request, check each done strobe
  always @(posedge clk) begin : mon
    rot_res_t want;
    if (!rst) begin
      if (start && !busy) begin
        rotated_q = {rotated_q,
                     rotate_predict('{rx: rot_x, ry: rot_y, rz: rot_z, rw: rot_w,
                                      vx: vec_x, vy: vec_y, vz: vec_z, vw: vec_w})};
        accepted_n <= accepted_n + 1;
      end
      if (done) begin
        if (rotated_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d sat=%0b",
                   $time, out_x, out_y, out_z, out_w, saturated);
          mismatch_n++;
        end else begin
          want = rotated_q.pop_front();
          check_field("out_x", want.x, out_x);
          check_field("out_y", want.y, out_y);
          check_field("out_z", want.z, out_z);
          check_field("out_w", want.w, out_w);
          check_field("saturated", want.sat, saturated);
        end
      end
    end
  end

  initial begin
    int kind;
    int c, s, axis;
    int rq[4];
    int vq[4];

    // Directed: identity, axis turns, extremes, zero inputs, vec_w, non-unit q
    add_req(0, 0, 0, 16384, 16384, -16384, 8192, 0);
    add_req(0, 0, 11585, 11585, 16384, 0, 0, 0);
    add_req(16384, 0, 0, 0, 0, 16384, 0, 0);
    add_req(0, 16384, 0, 0, 5000, -7000, 3000, 0);
    add_req(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_req(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    add_req(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
    add_req(0, 0, 0, 0, 12345, -2345, 345, -45);
    add_req(1000, -2000, 3000, 16384, 0, 0, 0, 0);
    add_req(0, 0, 0, 16384, 0, 0, 0, 16384);
    add_req(8192, 8192, 8192, 8192, 1, -1, 1, -1);
    add_req(0, 0, 0, 32767, 16384, -16384, 16384, 0);
    add_req(-32768, 0, 0, 0, 0, -32768, 0, 0);
    add_req(21845, -21846, 21845, -21846, -21846, 21845, -21846, 21845);
    add_req(-21846, 21845, -21846, 21845, 21845, -21846, 21845, -21846);
    add_req(-1, -1, -1, -1, -1, -1, -1, -1);
    add_req(1, 1, 1, 1, 1, 1, 1, 1);
    add_req(0, 0, 0, -16384, 32767, -32768, 0, 0);
    add_req(32767, 0, 0, 0, -32768, 0, 0, 0);
    add_req(0, 0, -32768, 0, 32767, 32767, 32767, 0);
    add_req(11585, 0, 0, -11585, 0, 16384, -16384, -8192);

    // Random: four in ten are unit rotations about an axis, the rest free-form
    for (int i = 0; i < RAND_REQS; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        case ($urandom_range(0, 5))
          0: begin c = 16384; s = 0; end
          1: begin c = 11585; s = 11585; end
          2: begin c = 0; s = 16384; end
          3: begin c = 14189; s = 8192; end
          4: begin c = 15137; s = 6270; end
          default: begin c = 16069; s = 3196; end
        endcase
        if ($urandom_range(0, 1)) s = -s;
        if ($urandom_range(0, 1)) c = -c;
        axis = $urandom_range(0, 2);
        rq = '{0, 0, 0, c};
        rq[axis] = s;
        for (int k = 0; k < 3; k++) vq[k] = pick_field(1);
        vq[3] = ($urandom_range(0, 9) == 0) ? pick_field(1) : 0;
      end else begin
        for (int k = 0; k < 4; k++) begin
          rq[k] = pick_field(kind < 7 ? 1 : (kind < 9 ? 0 : $urandom_range(0, 2)));
          vq[k] = pick_field(kind < 7 ? 1 : (kind < 9 ? 0 : $urandom_range(0, 2)));
        end
      end
      add_req(rq[0], rq[1], rq[2], rq[3], vq[0], vq[1], vq[2], vq[3]);
    end
    total_reqs = pending_reqs.size();

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    while (accepted_n < total_reqs) @(posedge clk);
    while (rotated_q.size() > 0) @(posedge clk);
    // pipeline is five deep; watch a little longer for stray strobes
    repeat (12) @(posedge clk);

    if (mismatch_n == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/qvr_pkg.sv
rtl/qvr_qmul.sv
rtl/qvr_sat.sv
rtl/quaternion_vector_rotate_unit.sv
verif/quaternion_vector_rotate_unit_tb.sv
